FILE: src/rse_pkg.sv
// rse_pkg: token kinds, ALU operation codes, status codes and widths shared by
// the postfix evaluator modules. No dependencies.
`default_nettype none

package rse_pkg;

  localparam int DATA_W    = 32;
  localparam int REQ_W     = 4;
  localparam int CNT_W     = 7;
  localparam int DIV_STEPS = 32;

  // Token kinds carried on req_type
  typedef enum logic [REQ_W-1:0] {
    TOK_NUM = 4'd0,
    TOK_ADD = 4'd1,
    TOK_SUB = 4'd2,
    TOK_MUL = 4'd3,
    TOK_DIV = 4'd4,
    TOK_NEG = 4'd5,
    TOK_IF  = 4'd6,
    TOK_MAX = 4'd7,
    TOK_MIN = 4'd8
  } tok_e;

  // Operations of the shared combinational ALU
  typedef enum logic [2:0] {
    ALU_PASS,
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_NEG,
    ALU_SEL,
    ALU_MAX,
    ALU_MIN
  } alu_op_e;

  // Sticky status reported with each result
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DIV0  = 2'd1,
    ST_UNDER = 2'd2,
    ST_OVER  = 2'd3
  } status_e;

endpackage

`default_nettype wire

FILE: src/rse_stack_mem.sv
// rse_stack_mem: operand stack storage, one write port and one registered
// read port. Depends on rse_pkg for the data width.
`default_nettype none

module rse_stack_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                      clk_i,
  input  wire logic                      we_i,
  input  wire logic [AW-1:0]             waddr_i,
  input  wire logic [rse_pkg::DATA_W-1:0] wdata_i,
  input  wire logic [AW-1:0]             raddr_i,
  output logic      [rse_pkg::DATA_W-1:0] rdata_o
);

  logic [rse_pkg::DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

FILE: src/rse_alu.sv
// rse_alu: shared combinational arithmetic and compare unit (add, sub, mul,
// negate, select, max, min). Depends on rse_pkg.
`default_nettype none

module rse_alu (
  input  wire rse_pkg::alu_op_e                   op_i,
  input  wire logic signed [rse_pkg::DATA_W-1:0]  a_i,
  input  wire logic signed [rse_pkg::DATA_W-1:0]  b_i,
  input  wire logic signed [rse_pkg::DATA_W-1:0]  c_i,
  output logic      signed [rse_pkg::DATA_W-1:0]  y_o
);

  // a is the deeper operand, b the running value; c is the fallback of select
  always_comb begin
    case (op_i)
      rse_pkg::ALU_PASS: y_o = a_i;
      rse_pkg::ALU_ADD:  y_o = a_i + b_i;
      rse_pkg::ALU_SUB:  y_o = a_i - b_i;
      rse_pkg::ALU_MUL:  y_o = a_i * b_i;
      rse_pkg::ALU_NEG:  y_o = -a_i;
      rse_pkg::ALU_SEL:  y_o = (a_i > 32'sd0) ? b_i : c_i;
      rse_pkg::ALU_MAX:  y_o = (a_i > b_i) ? a_i : b_i;
      rse_pkg::ALU_MIN:  y_o = (a_i < b_i) ? a_i : b_i;
      default:           y_o = a_i;
    endcase
  end

endmodule

`default_nettype wire

FILE: src/rse_div.sv
// rse_div: iterative signed divider, truncating toward zero, one quotient bit
// per cycle (restoring). Depends on rse_pkg.
`default_nettype none

module rse_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [rse_pkg::DATA_W-1:0] dividend_i,
  input  wire logic [rse_pkg::DATA_W-1:0] divisor_i,
  output logic                            done_o,
  output logic      [rse_pkg::DATA_W-1:0] quotient_o
);

  localparam int W   = rse_pkg::DATA_W;
  localparam int CW  = $clog2(rse_pkg::DIV_STEPS + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  dvs_q, dvs_d;
  logic          neg_q, neg_d;
  logic [W-1:0]  shifted;
  logic [W:0]    diff;
  logic          fits;

  // remainder stays below the divisor magnitude (at most 2^31), so the
  // shifted partial remainder fits in W bits
  assign shifted = {rem_q[W-2:0], quo_q[W-1]};
  assign diff    = {1'b0, shifted} - {1'b0, dvs_q};
  assign fits    = ~diff[W];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(rse_pkg::DIV_STEPS);
      rem_d  = '0;
      quo_d  = dividend_i[W-1] ? (W'(0) - dividend_i) : dividend_i;
      dvs_d  = divisor_i[W-1] ? (W'(0) - divisor_i) : divisor_i;
      neg_d  = dividend_i[W-1] ^ divisor_i[W-1];
    end else if (busy_q) begin
      rem_d = fits ? diff[W-1:0] : shifted;
      quo_d = {quo_q[W-2:0], fits};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (W'(0) - quo_q) : quo_q;

endmodule

`default_nettype wire

FILE: src/rpn_stack_evaluator.sv
// Postfix evaluator: each token goes through S_CHK and S_END; an operator that
// pops n operands also passes S_FETCH (one stack read per cycle) and S_WB, and a
// divide waits in S_DIV for the 32 quotient bits (one per cycle) before S_WB.
// A token marked last also passes S_TOP before its item appears on the output
// register. in_stall_o is high while a token is worked on. rst_ni (async, active
// low) empties the stack and clears the error. Depends on rse_pkg and submodules.
`default_nettype none

module rpn_stack_evaluator #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [3:0]           req_type_i,
  input  wire logic signed [31:0]   value_i,
  input  wire logic [6:0]           arg_count_i,
  input  wire logic                 end_of_expr_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic signed [31:0]        result_o,
  output logic [1:0]                status_o,
  output logic [6:0]                depth_left_o
);

  localparam int W   = rse_pkg::DATA_W;
  localparam int CW  = rse_pkg::CNT_W;
  localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int NW  = (SPW > CW) ? SPW : CW;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHK   = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_WB    = 3'd4;
  localparam logic [2:0] S_END   = 3'd5;
  localparam logic [2:0] S_TOP   = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [SPW-1:0]   sp_q, sp_d;
  rse_pkg::status_e err_q, err_d;
  rse_pkg::tok_e    kind_q, kind_d;
  logic [W-1:0]     val_q, val_d;
  logic [CW-1:0]    n_q, n_d;
  logic             last_q, last_d;
  logic [CW-1:0]    iss_q, iss_d;
  logic [CW-1:0]    prc_q, prc_d;
  logic             rv_q, rv_d;
  logic [W-1:0]     acc_q, acc_d;
  logic [W-1:0]     sec_q, sec_d;
  logic             out_valid_q, out_valid_d;
  logic [W-1:0]     res_q, res_d;
  logic [1:0]       stat_q, stat_d;
  logic [CW-1:0]    dep_q, dep_d;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [W-1:0]     mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [W-1:0]     mem_rdata;

  rse_pkg::alu_op_e alu_op;
  logic [W-1:0]     alu_y;
  logic             div_start;
  logic             div_done;
  logic [W-1:0]     div_q;

  logic [SPW-1:0]   sp_m1;
  logic [SPW-1:0]   rd_fetch;
  logic [SPW-1:0]   wb_base;
  logic [CW-1:0]    need;

  assign sp_m1    = sp_q - SPW'(1);
  assign rd_fetch = sp_q - SPW'(1) - SPW'(iss_q);
  assign wb_base  = sp_q - SPW'(n_q);

  // operand count per operator; max and min take the latched arg count
  always_comb begin
    case (kind_q)
      rse_pkg::TOK_ADD, rse_pkg::TOK_SUB,
      rse_pkg::TOK_MUL, rse_pkg::TOK_DIV: need = CW'(2);
      rse_pkg::TOK_NEG:                   need = CW'(1);
      rse_pkg::TOK_IF:                    need = CW'(3);
      rse_pkg::TOK_MAX, rse_pkg::TOK_MIN: need = n_q;
      default:                            need = '0;
    endcase
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    sp_d        = sp_q;
    err_d       = err_q;
    kind_d      = kind_q;
    val_d       = val_q;
    n_d         = n_q;
    last_d      = last_q;
    iss_d       = iss_q;
    prc_d       = prc_q;
    rv_d        = rv_q;
    acc_d       = acc_q;
    sec_d       = sec_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;
    stat_d      = stat_q;
    dep_d       = dep_q;
    mem_we      = 1'b0;
    mem_waddr   = sp_q[AW-1:0];
    mem_wdata   = acc_q;
    mem_raddr   = sp_m1[AW-1:0];
    alu_op      = rse_pkg::ALU_PASS;
    div_start   = 1'b0;

    // output register drains independently of the sequencer
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d  = rse_pkg::tok_e'(req_type_i);
          val_d   = value_i;
          n_d     = arg_count_i;
          last_d  = end_of_expr_i;
          state_d = S_CHK;
        end
      end

      S_CHK: begin
        state_d = S_END;
        if (err_q == rse_pkg::ST_OK) begin
          case (kind_q)
            rse_pkg::TOK_NUM: begin
              if (sp_q == SPW'(STACK_DEPTH)) begin
                err_d = rse_pkg::ST_OVER;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = sp_q[AW-1:0];
                mem_wdata = val_q;
                sp_d      = sp_q + SPW'(1);
              end
            end
            rse_pkg::TOK_ADD, rse_pkg::TOK_SUB, rse_pkg::TOK_MUL,
            rse_pkg::TOK_DIV, rse_pkg::TOK_NEG, rse_pkg::TOK_IF,
            rse_pkg::TOK_MAX, rse_pkg::TOK_MIN: begin
              n_d = need;
              if (need == '0 || NW'(need) > NW'(sp_q)) begin
                err_d = rse_pkg::ST_UNDER;
              end else begin
                iss_d   = '0;
                prc_d   = '0;
                rv_d    = 1'b0;
                state_d = S_FETCH;
              end
            end
            default: ;  // unknown token leaves the stack alone
          endcase
        end
      end

      S_FETCH: begin
        // issue one stack read per cycle, top first
        rv_d = 1'b0;
        if (iss_q < n_q) begin
          mem_raddr = rd_fetch[AW-1:0];
          iss_d     = iss_q + CW'(1);
          rv_d      = 1'b1;
        end
        // fold the operand returned from the previous read
        if (rv_q) begin
          prc_d = prc_q + CW'(1);
          if (prc_q == '0) begin
            alu_op = (kind_q == rse_pkg::TOK_NEG) ? rse_pkg::ALU_NEG : rse_pkg::ALU_PASS;
            acc_d  = alu_y;
          end else if (kind_q == rse_pkg::TOK_DIV) begin
            if (acc_q == '0) begin
              err_d   = rse_pkg::ST_DIV0;
              state_d = S_END;
            end else begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end else if (kind_q == rse_pkg::TOK_IF && prc_q == CW'(1)) begin
            sec_d = mem_rdata;
          end else begin
            case (kind_q)
              rse_pkg::TOK_ADD: alu_op = rse_pkg::ALU_ADD;
              rse_pkg::TOK_SUB: alu_op = rse_pkg::ALU_SUB;
              rse_pkg::TOK_MUL: alu_op = rse_pkg::ALU_MUL;
              rse_pkg::TOK_IF:  alu_op = rse_pkg::ALU_SEL;
              rse_pkg::TOK_MAX: alu_op = rse_pkg::ALU_MAX;
              rse_pkg::TOK_MIN: alu_op = rse_pkg::ALU_MIN;
              default:          alu_op = rse_pkg::ALU_PASS;
            endcase
            acc_d = alu_y;
          end
          if (prc_q == n_q - CW'(1) && kind_q != rse_pkg::TOK_DIV) begin
            state_d = S_WB;
          end
        end
      end

      S_DIV: begin
        if (div_done) begin
          acc_d   = div_q;
          state_d = S_WB;
        end
      end

      S_WB: begin
        mem_we    = 1'b1;
        mem_waddr = wb_base[AW-1:0];
        mem_wdata = acc_q;
        sp_d      = wb_base + SPW'(1);
        state_d   = S_END;
      end

      S_END: begin
        state_d = last_q ? S_TOP : S_IDLE;
      end

      S_TOP: begin
        // top-of-stack read stays addressed at sp - 1
        if (!out_valid_q || !out_stall_i) begin
          res_d       = (err_q == rse_pkg::ST_OK && sp_q != '0) ? mem_rdata : '0;
          stat_d      = err_q;
          dep_d       = CW'(sp_q);
          out_valid_d = 1'b1;
          sp_d        = '0;
          err_d       = rse_pkg::ST_OK;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      err_q       <= rse_pkg::ST_OK;
      out_valid_q <= 1'b0;
      rv_q        <= 1'b0;
      iss_q       <= '0;
      prc_q       <= '0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      rv_q        <= rv_d;
      iss_q       <= iss_d;
      prc_q       <= prc_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    val_q  <= val_d;
    n_q    <= n_d;
    last_q <= last_d;
    acc_q  <= acc_d;
    sec_q  <= sec_d;
    res_q  <= res_d;
    stat_q <= stat_d;
    dep_q  <= dep_d;
  end

  rse_stack_mem #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  rse_alu u_alu (
    .op_i (alu_op),
    .a_i  (mem_rdata),
    .b_i  ((kind_q == rse_pkg::TOK_IF) ? sec_q : acc_q),
    .c_i  (acc_q),
    .y_o  (alu_y)
  );

  rse_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mem_rdata),
    .divisor_i  (acc_q),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign result_o     = res_q;
  assign status_o     = stat_q;
  assign depth_left_o = dep_q;

endmodule

`default_nettype wire

FILE: src/rse_checker.sv
// rse_checker: port-level assertions for rpn_stack_evaluator, attached by the
// bind statement at the end of this file. Depends on rse_pkg.
`default_nettype none

module rse_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic signed [31:0] result_o,
  input wire logic [1:0]         status_o,
  input wire logic [6:0]         depth_left_o
);

  // a stalled result item stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  // a stalled result item keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(result_o) && $stable(status_o) && $stable(depth_left_o))
    else $error("result payload changed while stalled");

  // an accepted token keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after an item");

  // a new result only follows a token being worked on
  a_out_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result item without a token in flight");

  // an error status always reports a zero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != rse_pkg::ST_OK |-> result_o == 32'sd0)
    else $error("nonzero result with error status");

endmodule

bind rpn_stack_evaluator rse_checker u_rse_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .result_o     (result_o),
  .status_o     (status_o),
  .depth_left_o (depth_left_o)
);

`default_nettype wire
